// ===== rtl/mass_histogram_binner_unit_assert.svh =====
// Assertion macros used by the top-level RTL module.
`ifndef MASS_HISTOGRAM_BINNER_UNIT_ASSERT_SVH
`define MASS_HISTOGRAM_BINNER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHB_ASSERT(lbl, prop, msg)
`define MHB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/mhb_pkg.sv =====
`timescale 1ns / 1ps
package mhb_pkg;

  localparam int MAX_BINS  = 4096;
  localparam int BIN_AW    = $clog2(MAX_BINS);
  localparam int IDX_W     = 12;
  localparam int NB_W      = 13;
  localparam int CNT_W     = 16;
  localparam int WGT_W     = 17;
  localparam int DIV_W     = 34;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] REQ_BUILD = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_OTHER = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLAMP   = 2'd1;
  localparam logic [1:0] ST_NOCOUNT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_GROWTH = 3'd2;
  localparam logic [2:0] REG_LOW    = 3'd3;
  localparam logic [2:0] REG_HIGH   = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] mass;
  } in_beat_t;

  typedef struct packed {
    logic [WGT_W-1:0] weight;
    logic [IDX_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;
    logic [NB_W-1:0]  number_of_bins;
    logic [1:0]       status;
  } out_beat_t;

  typedef struct packed {
    logic        relative_mode;
    logic [31:0] bin_width;
    logic [31:0] growth_factor;
    logic [31:0] lowest_mass;
    logic [31:0] highest_mass;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } queue_head_t;

endpackage

// ===== rtl/mass_histogram_binner_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake         Payload
// in_       input      in_valid/in_stall  in_beat_t  (req_type, mass)
// out_      output     out_valid/out_stall out_beat_t (weight .. status)
// apb       input      psel/penable/pready five registers at 4*i
//
// Build: a clear pass over all counts, then a divide (absolute) or a check and
// an add step per table entry (relative). Add/query: a divide or a binary table
// search, a count read-modify-write, and a divide for the weight.
// After reset a pass clears all 4096 counts; in_stall stays high meanwhile.
// A two-beat queue takes in_ beats until full while a result waits on out_stall.
module mass_histogram_binner_unit import mhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "mass_histogram_binner_unit_assert.svh"

  cfg_t        cfg_r, cfg_nxt;
  queue_head_t head;
  logic        pop, init_busy, wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (paddr[4:2])
        REG_MODE:   cfg_nxt.relative_mode = pwdata[0];
        REG_WIDTH:  cfg_nxt.bin_width     = pwdata;
        REG_GROWTH: cfg_nxt.growth_factor = pwdata;
        REG_LOW:    cfg_nxt.lowest_mass   = pwdata;
        REG_HIGH:   cfg_nxt.highest_mass  = pwdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE:   prdata = {31'h0, cfg_r.relative_mode};
      REG_WIDTH:  prdata = cfg_r.bin_width;
      REG_GROWTH: prdata = cfg_r.growth_factor;
      REG_LOW:    prdata = cfg_r.lowest_mass;
      REG_HIGH:   prdata = cfg_r.highest_mass;
      default:    prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relative_mode <= 1'b0;
      cfg_r.bin_width     <= 32'd655360;
      cfg_r.growth_factor <= 32'd42950;
      cfg_r.lowest_mass   <= 32'd0;
      cfg_r.highest_mass  <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mhb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .hold     (init_busy),
    .head     (head),
    .pop      (pop)
  );

  mhb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  `MHB_ASSERT(a_weight_max, out_valid |-> out_beat.weight <= 17'd65536, "weight above one")
  `MHB_ASSERT(a_bins_max, out_valid |-> out_beat.number_of_bins <= 13'd4096, "too many bins")
  `MHB_ASSERT(a_idx_range, (out_valid && out_beat.number_of_bins != 13'd0) |-> (13'(out_beat.bin_index) < out_beat.number_of_bins), "bin index out of range")
  `MHB_ASSERT_RST(a_init_stall, !rst_n |=> in_stall, "input open during count clear")

endmodule

// ===== rtl/mhb_front.sv =====
`timescale 1ns / 1ps
module mhb_front import mhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  input  logic        hold,
  output queue_head_t head,
  input  logic        pop
);

  in_beat_t    slot_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  assign in_stall = (cnt_r == 2'd2) || hold;
  assign push     = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.beat  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_beat;
    end
  end

endmodule

// ===== rtl/mhb_div.sv =====
`timescale 1ns / 1ps
module mhb_div import mhb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-2:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [DIV_W-2:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;
  logic [DIV_W-1:0] sh;
  logic             ge;

  assign done = done_r;
  assign quot = quo_r;

  always_comb begin
    sh       = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
    ge       = (sh >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CW'(DIV_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? (sh - {1'b0, dvs_r}) : sh;
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

// ===== rtl/mhb_core.sv =====
`timescale 1ns / 1ps
module mhb_core import mhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  queue_head_t head,
  output logic        pop,
  output logic        init_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat
);

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_CLR  = 5'd2;
  localparam logic [4:0] S_BDIV = 5'd3;
  localparam logic [4:0] S_RCHK = 5'd4;
  localparam logic [4:0] S_RADD = 5'd5;
  localparam logic [4:0] S_BS   = 5'd6;
  localparam logic [4:0] S_BSC  = 5'd7;
  localparam logic [4:0] S_BSE  = 5'd8;
  localparam logic [4:0] S_NA   = 5'd9;
  localparam logic [4:0] S_NB   = 5'd10;
  localparam logic [4:0] S_NC   = 5'd11;
  localparam logic [4:0] S_PDIV = 5'd12;
  localparam logic [4:0] S_CRD  = 5'd13;
  localparam logic [4:0] S_CUP  = 5'd14;
  localparam logic [4:0] S_WDIV = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  localparam int BW = $clog2(BIN_AW + 1);
  localparam int TW = BIN_AW + 2;

  logic [31:0] tbl_mem [MAX_BINS];
  logic [CNT_W-1:0] cnt_mem [MAX_BINS];
  logic [31:0]      tbl_q_r;
  logic [CNT_W-1:0] cnt_q_r;

  logic [4:0]       state_r, state_nxt;
  in_beat_t         beat_r, beat_nxt;
  logic [NB_W-1:0]  bins_r, bins_nxt;
  logic [CNT_W-1:0] max_r, max_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [WGT_W-1:0] weight_r, weight_nxt;
  logic [NB_W-1:0]  clr_r, clr_nxt;
  logic [33:0]      cur_r, cur_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [NB_W-1:0]  nrel_r, nrel_nxt;
  logic [NB_W-1:0]  bsc_r, bsc_nxt;
  logic [BW-1:0]    bsb_r, bsb_nxt;
  logic [31:0]      t0_r, t0_nxt;
  out_beat_t        out_r, out_nxt;
  logic             ov_r, ov_nxt;

  logic             tbl_we;
  logic [BIN_AW-1:0] tbl_wa, tbl_ra, cnt_wa, cnt_ra;
  logic [31:0]      tbl_wd;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wd;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dnd, div_q;
  logic [DIV_W-2:0] div_dvs;

  logic [31:0]      w_eff, span, d, m, dl, dr;
  logic [63:0]      psum;
  logic [31:0]      step;
  logic [TW-1:0]    t;
  logic [CNT_W-1:0] c, newmax;
  logic             out_free;

  mhb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dnd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  assign init_busy = (state_r == S_INIT);
  assign out_valid = ov_r;
  assign out_beat  = out_r;

  always_comb begin
    w_eff    = (cfg.bin_width == 32'd0) ? 32'd1 : cfg.bin_width;
    span     = (cfg.highest_mass > cfg.lowest_mass) ?
               (cfg.highest_mass - cfg.lowest_mass) : 32'd0;
    d        = head.beat.mass - cfg.lowest_mass;
    m        = beat_r.mass;
    psum     = prod_r + 64'h8000_0000;
    step     = (psum[63:32] == 32'd0) ? 32'd1 : psum[63:32];
    t        = TW'(bsc_r) + (TW'(1) << bsb_r);
    dl       = m - t0_r;
    dr       = (tbl_q_r >= m) ? (tbl_q_r - m) : (m - tbl_q_r);
    out_free = !ov_r || !out_stall;
    c        = cnt_q_r;
    newmax   = max_r;

    state_nxt  = state_r;
    beat_nxt   = beat_r;
    bins_nxt   = bins_r;
    max_nxt    = max_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    weight_nxt = weight_r;
    clr_nxt    = clr_r;
    cur_nxt    = cur_r;
    prod_nxt   = prod_r;
    nrel_nxt   = nrel_r;
    bsc_nxt    = bsc_r;
    bsb_nxt    = bsb_r;
    t0_nxt     = t0_r;
    out_nxt    = out_r;
    ov_nxt     = (ov_r && !out_stall) ? 1'b0 : ov_r;

    pop       = 1'b0;
    div_start = 1'b0;
    div_dnd   = '0;
    div_dvs   = '0;
    tbl_we    = 1'b0;
    tbl_wa    = nrel_r[BIN_AW-1:0];
    tbl_wd    = cur_r[31:0];
    tbl_ra    = idx_r;
    cnt_we    = 1'b0;
    cnt_wa    = clr_r[BIN_AW-1:0];
    cnt_wd    = '0;
    cnt_ra    = idx_r;

    case (state_r)
      S_INIT: begin
        cnt_we  = 1'b1;
        clr_nxt = clr_r + NB_W'(1);
        if (clr_r == NB_W'(MAX_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          beat_nxt   = head.beat;
          weight_nxt = '0;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          status_nxt = ST_OK;
          case (head.beat.req_type)
            REQ_BUILD: begin
              max_nxt   = '0;
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            REQ_ADD, REQ_QUERY: begin
              if (bins_r == '0) begin
                status_nxt = ST_NOCOUNT;
                state_nxt  = S_OUT;
              end else begin
                if (head.beat.mass < cfg.lowest_mass ||
                    head.beat.mass > cfg.highest_mass) begin
                  status_nxt = ST_CLAMP;
                end
                if (cfg.relative_mode) begin
                  bsc_nxt   = '0;
                  bsb_nxt   = BW'(BIN_AW);
                  state_nxt = S_BS;
                end else if (head.beat.mass < cfg.lowest_mass) begin
                  state_nxt = S_CRD;
                end else begin
                  div_start = 1'b1;
                  div_dnd   = {1'b0, d, 1'b0} + {2'b00, w_eff};
                  div_dvs   = {w_eff, 1'b0};
                  state_nxt = S_PDIV;
                end
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_CLR: begin
        cnt_we  = 1'b1;
        clr_nxt = clr_r + NB_W'(1);
        if (clr_r == NB_W'(MAX_BINS - 1)) begin
          if (cfg.relative_mode) begin
            cur_nxt   = {2'b00, cfg.lowest_mass};
            nrel_nxt  = '0;
            state_nxt = S_RCHK;
          end else begin
            div_start = 1'b1;
            div_dnd   = {2'b00, span} + {2'b00, w_eff} - DIV_W'(1);
            div_dvs   = {1'b0, w_eff};
            state_nxt = S_BDIV;
          end
        end
      end
      S_BDIV: begin
        if (div_done) begin
          if (div_q > DIV_W'(MAX_BINS - 2)) begin
            bins_nxt   = NB_W'(MAX_BINS);
            status_nxt = ST_FULL;
          end else begin
            bins_nxt = div_q[NB_W-1:0] + NB_W'(2);
          end
          state_nxt = S_OUT;
        end
      end
      S_RCHK: begin
        if (cur_r < {2'b00, cfg.highest_mass}) begin
          if (nrel_r == NB_W'(MAX_BINS)) begin
            status_nxt = ST_FULL;
            bins_nxt   = nrel_r;
            state_nxt  = S_OUT;
          end else begin
            tbl_we    = 1'b1;
            nrel_nxt  = nrel_r + NB_W'(1);
            prod_nxt  = cur_r[31:0] * cfg.growth_factor;
            state_nxt = S_RADD;
          end
        end else begin
          bins_nxt  = nrel_r;
          state_nxt = S_OUT;
        end
      end
      S_RADD: begin
        cur_nxt   = cur_r + {2'b00, step};
        state_nxt = S_RCHK;
      end
      S_BS: begin
        if (t <= TW'(bins_r)) begin
          tbl_ra    = BIN_AW'(t - TW'(1));
          state_nxt = S_BSC;
        end else if (bsb_r == '0) begin
          state_nxt = S_BSE;
        end else begin
          bsb_nxt = bsb_r - BW'(1);
        end
      end
      S_BSC: begin
        if (tbl_q_r <= m) begin
          bsc_nxt = t[NB_W-1:0];
        end
        if (bsb_r == '0) begin
          state_nxt = S_BSE;
        end else begin
          bsb_nxt   = bsb_r - BW'(1);
          state_nxt = S_BS;
        end
      end
      S_BSE: begin
        if (bsc_r == '0) begin
          idx_nxt   = '0;
          state_nxt = S_CRD;
        end else begin
          idx_nxt   = IDX_W'(bsc_r - NB_W'(1));
          state_nxt = (bsc_r < bins_r) ? S_NA : S_CRD;
        end
      end
      S_NA: begin
        state_nxt = S_NB;
      end
      S_NB: begin
        tbl_ra    = idx_r + IDX_W'(1);
        t0_nxt    = tbl_q_r;
        state_nxt = S_NC;
      end
      S_NC: begin
        if (!(dl < dr)) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        state_nxt = S_CRD;
      end
      S_PDIV: begin
        if (div_done) begin
          if (div_q >= DIV_W'(bins_r)) begin
            idx_nxt = IDX_W'(bins_r - NB_W'(1));
          end else begin
            idx_nxt = div_q[IDX_W-1:0];
          end
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        state_nxt = S_CUP;
      end
      S_CUP: begin
        if (beat_r.req_type == REQ_ADD) begin
          if (cnt_q_r != CNT_MAX) begin
            c = cnt_q_r + CNT_W'(1);
          end
          cnt_we = 1'b1;
          cnt_wa = idx_r;
          cnt_wd = c;
          if (c > max_r) begin
            newmax = c;
          end
        end
        max_nxt = newmax;
        cnt_nxt = c;
        if (newmax == '0) begin
          if (beat_r.req_type == REQ_QUERY) begin
            status_nxt = ST_NOCOUNT;
          end
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          div_dnd   = {2'b00, c, 16'h0000};
          div_dvs   = {17'h0_0000, newmax};
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_done) begin
          weight_nxt = div_q[WGT_W-1:0];
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt                 = 1'b1;
          out_nxt.weight         = weight_r;
          out_nxt.bin_index      = idx_r;
          out_nxt.bin_count      = cnt_r;
          out_nxt.number_of_bins = bins_r;
          out_nxt.status         = status_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      bins_r  <= '0;
      max_r   <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bins_r  <= bins_nxt;
      max_r   <= max_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r   <= beat_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    weight_r <= weight_nxt;
    cur_r    <= cur_nxt;
    prod_r   <= prod_nxt;
    nrel_r   <= nrel_nxt;
    bsc_r    <= bsc_nxt;
    bsb_r    <= bsb_nxt;
    t0_r     <= t0_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q_r <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q_r <= cnt_mem[cnt_ra];
  end

endmodule
